@@ src/binary_max_heap_queue_assert.svh @@
// assertion helpers for the heap queue, clocked on aclk, off while in reset
`ifndef BINARY_MAX_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MAX_HEAP_QUEUE_ASSERT_SVH

// same-cycle implication
`define BMHQ_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BMHQ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/bmhq_pkg.sv @@
package bmhq_pkg;

    localparam int KEY_W     = 32;
    localparam int VAL_W     = 16;
    localparam int CNT_OUT_W = 11;
    localparam int ERR_W     = 2;

    // operation select carried on tuser
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

    typedef struct packed {
        logic [VAL_W-1:0]        value;
        logic signed [KEY_W-1:0] key;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_READ,
        ST_UP_EVAL,
        ST_POP_LOAD,
        ST_DOWN_READ,
        ST_DOWN_EVAL,
        ST_FIN
    } state_t;

endpackage

@@ src/binary_max_heap_queue.sv @@
// binary max-heap priority queue, one result word per input word, one word in work at a time
// a push climbs from the new last slot, a pop loads the last slot and sinks it from the root;
// each level is a read state then a compare-and-write state; rejected words go straight to the
// result state; the next word is taken while the last result waits; aresetn (sync, active low)
// empties the heap, memory kept
`include "binary_max_heap_queue_assert.svh"

module binary_max_heap_queue
    import bmhq_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input word
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] key (signed), [47:32] value
    input  logic        s_tuser,   // func: 0 push, 1 pop
    // result word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [31:0] top_key, [47:32] top_value, [58:48] count,
                                   // [59] is_empty, [61:60] error, [63:62] zero
);

    localparam int AW  = $clog2(DEPTH);      // heap index width
    localparam int CW  = $clog2(DEPTH + 1);  // entry count width
    localparam int CAW = AW + 2;             // child index width, room for 2*i+2
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // sequencer state
    state_t           state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;         // entries held
    logic [AW-1:0]    hole_reg, hole_next;       // slot the moving entry may land in
    entry_t           item_reg, item_next;       // entry being sifted
    entry_t           top_reg;                   // shadow of the root slot
    logic [ERR_W-1:0] err_reg, err_next;

    // result register
    logic             m_tvalid_reg, m_tvalid_next;
    logic [63:0]      m_tdata_reg, m_tdata_next;

    // heap memory port
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    entry_t           ram_wdata;
    logic [AW-1:0]    ram_raddr_a, ram_raddr_b;
    entry_t           ram_rdata_a, ram_rdata_b;

    // index arithmetic
    logic [AW-1:0]    hole_dec;
    logic [AW-1:0]    parent_idx;
    logic [CW-1:0]    cnt_dec;
    logic [CAW-1:0]   cnt_ext;
    logic [CAW-1:0]   child_l, child_r;
    logic             right_bigger;
    entry_t           child_sel;
    logic [AW-1:0]    child_sel_idx;

    // input word fields
    logic             in_func;
    entry_t           in_entry;
    logic             in_accept;

    // result word fields
    logic             res_empty;
    logic [KEY_W-1:0] res_key;
    logic [VAL_W-1:0] res_val;

    assign in_func        = s_tuser;
    assign in_entry.key   = s_tdata[KEY_W-1:0];
    assign in_entry.value = s_tdata[KEY_W+VAL_W-1:KEY_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    assign hole_dec   = hole_reg - 1'b1;
    assign parent_idx = hole_dec >> 1;
    assign cnt_dec    = cnt_reg - 1'b1;
    assign cnt_ext    = {{(CAW-CW){1'b0}}, cnt_reg};
    assign child_l    = {1'b0, hole_reg, 1'b1};
    assign child_r    = child_l + 1'b1;

    // larger child, left one on a tie; right only counts when it exists
    assign right_bigger  = (child_r < cnt_ext) &&
                           ($signed(ram_rdata_b.key) > $signed(ram_rdata_a.key));
    assign child_sel     = right_bigger ? ram_rdata_b : ram_rdata_a;
    assign child_sel_idx = right_bigger ? child_r[AW-1:0] : child_l[AW-1:0];

    assign res_empty = (cnt_reg == '0);
    assign res_key   = res_empty ? '0 : top_reg.key;
    assign res_val   = res_empty ? '0 : top_reg.value;

    bmhq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        hole_next     = hole_reg;
        item_next     = item_reg;
        err_next      = err_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        ram_we        = 1'b0;
        ram_waddr     = hole_reg;
        ram_wdata     = item_reg;
        ram_raddr_a   = cnt_dec[AW-1:0];
        ram_raddr_b   = child_r[AW-1:0];

        // result taken downstream
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                // the read of the last slot is issued here for a pop
                if (in_accept) begin
                    err_next = ERR_OK;
                    if (in_func == OP_PUSH) begin
                        if (cnt_reg == FULL_CNT) begin
                            err_next   = ERR_FULL;
                            state_next = ST_FIN;
                        end else begin
                            item_next  = in_entry;
                            hole_next  = cnt_reg[AW-1:0];
                            cnt_next   = cnt_reg + 1'b1;
                            state_next = ST_UP_READ;
                        end
                    end else begin
                        if (cnt_reg == '0) begin
                            err_next   = ERR_EMPTY;
                            state_next = ST_FIN;
                        end else begin
                            cnt_next   = cnt_dec;
                            state_next = ST_POP_LOAD;
                        end
                    end
                end
            end
            ST_UP_READ: begin
                ram_raddr_a = parent_idx;
                if (hole_reg == '0) begin
                    ram_we     = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_UP_EVAL;
                end
            end
            ST_UP_EVAL: begin
                ram_we = 1'b1;
                if ($signed(item_reg.key) > $signed(ram_rdata_a.key)) begin
                    // parent moves down into the hole
                    ram_wdata  = ram_rdata_a;
                    hole_next  = parent_idx;
                    state_next = ST_UP_READ;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_POP_LOAD: begin
                item_next  = ram_rdata_a;
                hole_next  = '0;
                state_next = ST_DOWN_READ;
            end
            ST_DOWN_READ: begin
                ram_raddr_a = child_l[AW-1:0];
                ram_raddr_b = child_r[AW-1:0];
                if (child_l >= cnt_ext) begin
                    // leaf reached; nothing to place once the heap is empty
                    ram_we     = (cnt_reg != '0);
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_DOWN_EVAL;
                end
            end
            ST_DOWN_EVAL: begin
                ram_we = 1'b1;
                if ($signed(child_sel.key) > $signed(item_reg.key)) begin
                    // larger child moves up into the hole
                    ram_wdata  = child_sel;
                    hole_next  = child_sel_idx;
                    state_next = ST_DOWN_READ;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, err_reg, res_empty, CNT_OUT_W'(cnt_reg),
                                     res_val, res_key};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        hole_reg    <= hole_next;
        item_reg    <= item_next;
        err_reg     <= err_next;
        m_tdata_reg <= m_tdata_next;
        // any write to the root also refreshes its shadow
        if (ram_we && (ram_waddr == '0)) begin
            top_reg <= ram_wdata;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `BMHQ_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_reg <= FULL_CNT,
        "entry count above depth")
    `BMHQ_ASSERT_IMPL(a_write_in_range, ram_we,
        {2'b00, ram_waddr} < cnt_ext, "heap write beyond held entries")
    `BMHQ_ASSERT_NEXT(a_pop_empty,
        in_accept && (in_func == OP_POP) && (cnt_reg == '0),
        (state_reg == ST_FIN) && (err_reg == ERR_EMPTY), "pop on empty not flagged")
    `BMHQ_ASSERT_NEXT(a_cnt_hold, state_reg != ST_IDLE, $stable(cnt_reg),
        "entry count changed during a sift")

endmodule

@@ src/bmhq_ram.sv @@
module bmhq_ram
    import bmhq_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr_a,
    output entry_t        rdata_a,
    input  logic [AW-1:0] raddr_b,
    output entry_t        rdata_b
);

    entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ test/binary_max_heap_queue_tb.sv @@
`timescale 1ns / 1ps

module binary_max_heap_queue_tb
    import bmhq_pkg::*;
();

    localparam int HEAP_DEPTH    = 1024;
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int SETTLE_CYCLES = 64;    // well past the deepest sift
    localparam int STALL_LIMIT   = 4000;  // cycles with no handshake at all
    localparam int MAX_PRINTS    = 40;

    // result word, lowest field last in the packed order
    typedef struct packed {
        logic [ERR_W-1:0]      error;
        logic                  is_empty;
        logic [CNT_OUT_W-1:0]  count;
        logic [VAL_W-1:0]      top_value;
        logic signed [KEY_W-1:0] top_key;
    } heap_result_t;

    typedef struct {
        logic         op;
        logic [31:0]  key;
        logic [15:0]  value;
        bit           fixed;
        heap_result_t want;
    } vector_t;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;

    // expectation override that travels with the word on the input side
    bit           s_fixed      = 1'b0;
    heap_result_t s_fixed_want = '0;

    // heap mirror
    entry_t heap_mirror [HEAP_DEPTH];
    int     heap_cnt = 0;

    heap_result_t results_due [$];
    int           mismatch_count = 0;
    idle_mode_t   idle_mode = IDLE_NONE;
    int           hold_req  = 0;
    int           hold_seen = 0;
    int           hold_left = 0;
    int           stall_cycles = 0;
    vector_t      directed [$];

    binary_max_heap_queue #(
        .DEPTH(HEAP_DEPTH)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),     // [31:0] key, [47:32] value
        .s_tuser(s_tuser),     // func
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)      // [31:0] top_key, [47:32] top_value, [58:48] count,
                               // [59] is_empty, [61:60] error
    );

    always #1 aclk = ~aclk;

    // applies one word to the mirror and returns the new top, count and flags
    function automatic heap_result_t heap_apply(logic op, logic [31:0] k, logic [15:0] v);
        heap_result_t r;
        entry_t       tmp;
        int           n;
        int           p;
        int           i;
        int           c;
        r = '0;
        r.error = ERR_OK;
        if (op == OP_PUSH) begin
            if (heap_cnt >= HEAP_DEPTH) begin
                r.error = ERR_FULL;
            end else begin
                n = heap_cnt;
                heap_mirror[n].key   = k;
                heap_mirror[n].value = v;
                heap_cnt = n + 1;
                // climb while strictly greater than the parent
                while (n != 0) begin
                    p = (n - 1) / 2;
                    if (!($signed(heap_mirror[n].key) > $signed(heap_mirror[p].key)))
                        break;
                    tmp = heap_mirror[n];
                    heap_mirror[n] = heap_mirror[p];
                    heap_mirror[p] = tmp;
                    n = p;
                end
            end
        end else begin
            if (heap_cnt == 0) begin
                r.error = ERR_EMPTY;
            end else begin
                n = heap_cnt - 1;
                heap_mirror[0] = heap_mirror[n];
                heap_cnt = n;
                i = 0;
                // sink toward the larger child, left one on a tie
                forever begin
                    c = 2 * i + 1;
                    if (c >= n)
                        break;
                    if (c + 1 < n &&
                        $signed(heap_mirror[c + 1].key) > $signed(heap_mirror[c].key))
                        c = c + 1;
                    if (!($signed(heap_mirror[c].key) > $signed(heap_mirror[i].key)))
                        break;
                    tmp = heap_mirror[i];
                    heap_mirror[i] = heap_mirror[c];
                    heap_mirror[c] = tmp;
                    i = c;
                end
            end
        end
        r.count = heap_cnt[CNT_OUT_W-1:0];
        if (heap_cnt == 0) begin
            r.is_empty = 1'b1;
        end else begin
            r.top_key   = heap_mirror[0].key;
            r.top_value = heap_mirror[0].value;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("mismatch @%0t: %s", $time, msg);
    endtask

    // random idling decision for one side in the current phase
    function automatic bit idle_now(input bit rx_side);
        case (idle_mode)
            IDLE_SENDER:   return !rx_side && $urandom_range(0, 99) < 82;
            IDLE_RECEIVER: return rx_side && $urandom_range(0, 99) < 82;
            IDLE_BOTH:     return $urandom_range(0, 99) < 7;
            default:       return 1'b0;
        endcase
    endfunction

    // keys: half from a narrow band to force ties, some extremes, the rest full range
    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 32'(int'($urandom_range(0, 15)) - 8);
            5:             return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default:       return $urandom;
        endcase
    endfunction

    // add one row to the directed table
    task automatic add_row(input logic op, input logic [31:0] k, input logic [15:0] v,
                           input bit fixed, input heap_result_t want);
        vector_t row;
        row.op    = op;
        row.key   = k;
        row.value = v;
        row.fixed = fixed;
        row.want  = want;
        directed.insert(directed.size(), row);
    endtask

    // offer one word, called and returning at a falling edge
    task automatic send_word(input logic op, input logic [31:0] k, input logic [15:0] v,
                             input bit fixed, input heap_result_t want);
        while (idle_now(1'b0)) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid     <= 1'b1;
        s_tuser      <= op;
        s_tdata      <= {v, k};
        s_fixed      <= fixed;
        s_fixed_want <= want;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_random(input logic op);
        send_word(op, pick_key(), 16'($urandom_range(0, 65535)), 1'b0, '0);
    endtask

    // hold the sender until every pending result has come back
    task automatic wait_results();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(negedge aclk);
    endtask

    // push-heavy and pop-heavy bursts so the heap grows and shrinks
    task automatic run_mix(input int items);
        int push_pct;
        push_pct = 70;
        for (int i = 0; i < items; i++) begin
            if (i % 60 == 0)
                push_pct = $urandom_range(20, 85);
            send_random(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP);
        end
    endtask

    // receiver: random stalls per phase, plus the long hold-off on request
    always @(negedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !idle_now(1'b1);
        end
    end

    // predict on every accepted input word, check every accepted result word
    always @(posedge aclk) begin : scoreboard
        heap_result_t got;
        heap_result_t want;
        heap_result_t calc;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                calc = heap_apply(s_tuser, s_tdata[31:0], s_tdata[47:32]);
                results_due.insert(results_due.size(), s_fixed ? s_fixed_want : calc);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[61:0];
                if (results_due.size() == 0) begin
                    report_mismatch($sformatf("result word with none pending: %h", m_tdata));
                end else begin
                    want = results_due.pop_front();
                    if (got.top_key !== want.top_key)
                        report_mismatch($sformatf("top_key %0d, want %0d",
                                                  got.top_key, want.top_key));
                    if (got.top_value !== want.top_value)
                        report_mismatch($sformatf("top_value %h, want %h",
                                                  got.top_value, want.top_value));
                    if (got.count !== want.count)
                        report_mismatch($sformatf("count %0d, want %0d",
                                                  got.count, want.count));
                    if (got.is_empty !== want.is_empty)
                        report_mismatch($sformatf("is_empty %b, want %b",
                                                  got.is_empty, want.is_empty));
                    if (got.error !== want.error)
                        report_mismatch($sformatf("error %0d, want %0d",
                                                  got.error, want.error));
                end
            end
        end
    end

    // watchdog: ends the run when no word moves on either side for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results pending",
                     stall_cycles, results_due.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        heap_cnt = 0;

        // directed table: typed expectations only where obvious
        //      op       key            value     fixed  {error, empty, count, value, key}
        add_row(OP_POP,  32'd0,         16'h0000, 1'b1, {ERR_EMPTY, 1'b1, 11'd0, 16'h0, 32'h0});
        add_row(OP_PUSH, 32'h7FFF_FFFF, 16'hFFFF, 1'b1,
                {ERR_OK, 1'b0, 11'd1, 16'hFFFF, 32'h7FFF_FFFF});
        add_row(OP_PUSH, 32'h8000_0000, 16'h0000, 1'b1,
                {ERR_OK, 1'b0, 11'd2, 16'hFFFF, 32'h7FFF_FFFF});
        add_row(OP_PUSH, 32'hFFFF_FFFF, 16'h0001, 1'b0, '0);
        add_row(OP_PUSH, 32'd0,         16'h8000, 1'b0, '0);
        // equal to the root: must not displace it
        add_row(OP_PUSH, 32'h7FFF_FFFF, 16'h1234, 1'b0, '0);
        // three equal keys, tie order on the way up and down
        add_row(OP_PUSH, 32'd5,         16'h0003, 1'b0, '0);
        add_row(OP_PUSH, 32'd5,         16'h0004, 1'b0, '0);
        add_row(OP_PUSH, 32'd5,         16'h0005, 1'b0, '0);
        add_row(OP_PUSH, 32'h8000_0000, 16'hFFFF, 1'b0, '0);
        for (int i = 0; i < 8; i++)
            add_row(OP_POP, 32'd0, 16'h0, 1'b0, '0);
        // last entry out, then pop on empty again
        add_row(OP_POP,  32'd0,         16'h0000, 1'b1, {ERR_OK, 1'b1, 11'd0, 16'h0, 32'h0});
        add_row(OP_POP,  32'd0,         16'h0000, 1'b1, {ERR_EMPTY, 1'b1, 11'd0, 16'h0, 32'h0});

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        idle_mode = IDLE_NONE;
        foreach (directed[i])
            send_word(directed[i].op, directed[i].key, directed[i].value,
                      directed[i].fixed, directed[i].want);
        wait_results();

        // fill to capacity under a long receiver hold, then push on full
        idle_mode = IDLE_BOTH;
        hold_req++;
        while (heap_cnt < HEAP_DEPTH)
            send_random(OP_PUSH);
        for (int i = 0; i < 4; i++)
            send_random(OP_PUSH);
        for (int i = 0; i < 6; i++)
            send_random((i % 2) ? OP_PUSH : OP_POP);
        wait_results();

        // random mix through every idling phase, starting from a full heap
        idle_mode = IDLE_NONE;
        hold_req++;
        run_mix(110);
        wait_results();
        idle_mode = IDLE_SENDER;
        run_mix(110);
        wait_results();
        idle_mode = IDLE_RECEIVER;
        run_mix(110);
        idle_mode = IDLE_BOTH;
        run_mix(110);

        wait_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
